// ----- rtl/core/raas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package raas_pkg;

  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int SCOORD_W   = 8;
  localparam int TCOORD_W   = 12;
  localparam int CFG_SRC_W  = 9;
  localparam int CFG_DST_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SPAN0_GO,
    S_SPAN0,
    S_SPAN1_GO,
    S_SPAN1,
    S_SUM,
    S_DRAIN,
    S_AVG_GO,
    S_AVG,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/raas_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface raas_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [raas_pkg::SCOORD_W-1:0]    source_col;
  logic [raas_pkg::SCOORD_W-1:0]    source_row;
  logic [raas_pkg::PIX_W-1:0]       source_pixel;
  logic [raas_pkg::TCOORD_W-1:0]    target_col;
  logic [raas_pkg::TCOORD_W-1:0]    target_row;

  modport source (
    output valid, mode, source_col, source_row, source_pixel, target_col, target_row,
    input  ready
  );
  modport sink (
    input  valid, mode, source_col, source_row, source_pixel, target_col, target_row,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/raas_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface raas_out_if;
  logic                       valid;
  logic                       ready;
  logic [raas_pkg::PIX_W-1:0] averaged_pixel;
  logic                       bad_request;

  modport source (
    output valid, averaged_pixel, bad_request,
    input  ready
  );
  modport sink (
    input  valid, averaged_pixel, bad_request,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/raas_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface raas_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [raas_pkg::CFG_IDX_W-1:0]  index;
  logic [raas_pkg::CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/raas_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Caller guarantees num < den * 2**QUO_W. done pulses with quo valid.
module raas_div #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int QUO_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int DSH_W  = DEN_W + QUO_W - 1;
  localparam int CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int STEP_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic [NUM_W-1:0]  rem_r;
  logic [DSH_W-1:0]  dsh_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;
  logic [NUM_W-1:0]  diff;

  assign ge   = CMP_W'(rem_r) >= CMP_W'(dsh_r);
  assign diff = NUM_W'(CMP_W'(rem_r) - CMP_W'(dsh_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      dsh_r  <= DSH_W'(den) << (QUO_W - 1);
      quo_r  <= '0;
      step_r <= STEP_W'(QUO_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff;
      end
      quo_r  <= QUO_W'({quo_r, ge});
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ----- rtl/core/rgba_area_average_scaler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake    Payload
// in_chan   in   valid/ready  mode, source_col/row, source_pixel, target_col/row
// out_chan  out  valid/ready  averaged_pixel, bad_request
// cfg_chan  in   valid/ready  index, data (ready tied high)
//
// A request reads the source pixels of its window through the single
// frame-memory read port, one pixel per cycle. An out-of-range request skips
// the divisions and goes straight to the output register. Reset clears
// control and sets all sizes to 1; the frame memory is not cleared. One request
// is in flight at a time; a finished result waits in the output register.
module rgba_area_average_scaler_core #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_DIM    = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  raas_in_if.sink    in_chan,
  raas_out_if.source out_chan,
  raas_cfg_if.sink   cfg_chan
);

  localparam int SW_W   = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SH_W   = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int T_W    = $clog2(MAX_DST_DIM + 1);
  localparam int SPAN_Q = (SW_W > SH_W) ? SW_W : SH_W;
  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int A_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ACC_W  = raas_pkg::CH_W + CNT_W;
  localparam int NX_W   = raas_pkg::TCOORD_W + SW_W + 1;
  localparam int NY_W   = raas_pkg::TCOORD_W + SH_W + 1;

  // configuration
  logic [raas_pkg::CFG_SRC_W-1:0] src_w_r, src_h_r;
  logic [raas_pkg::CFG_DST_W-1:0] dst_w_r, dst_h_r;
  logic [SW_W-1:0]                sw_eff;
  logic [SH_W-1:0]                sh_eff;
  logic [T_W-1:0]                 tw_eff, th_eff;

  raas_pkg::state_t state_r, state_nxt;

  logic in_ready, in_fire, is_req, req_bad, mem_we;
  logic span_go, avg_go, out_load;
  logic [A_W-1:0] wr_addr, rd_addr;

  logic [raas_pkg::TCOORD_W-1:0] dx_r, dy_r;
  logic [NX_W-1:0]               px_r, num_x;
  logic [NY_W-1:0]               py_r, num_y;
  logic                          spanx_done, spany_done;
  logic [SPAN_Q-1:0]             spanx_quo, spany_quo;
  logic [SPAN_Q-1:0]             bx, by;
  logic [SW_W-1:0]               x0_r, x1_r, x_r;
  logic [SH_W-1:0]               y0_r, y1_r, y_r;
  logic                          last_x, last_y;

  logic [raas_pkg::PIX_W-1:0] mem [DEPTH];
  logic [raas_pkg::PIX_W-1:0] rd_data_r;
  logic                       rd_valid_r;

  logic [ACC_W-1:0]  acc_r [raas_pkg::NUM_CH];
  logic [CNT_W-1:0]  cnt_r;
  logic [raas_pkg::NUM_CH-1:0] avg_done;
  logic [raas_pkg::CH_W-1:0]   avg_quo [raas_pkg::NUM_CH];

  logic [raas_pkg::PIX_W-1:0] res_pix_r, out_pix_r;
  logic                       res_bad_r, out_bad_r, out_valid_r;

  // ---------------- configuration registers ----------------
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= raas_pkg::CFG_SRC_W'(1);
      src_h_r <= raas_pkg::CFG_SRC_W'(1);
      dst_w_r <= raas_pkg::CFG_DST_W'(1);
      dst_h_r <= raas_pkg::CFG_DST_W'(1);
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        raas_pkg::CFG_SRC_WIDTH:  src_w_r <= raas_pkg::CFG_SRC_W'(cfg_chan.data);
        raas_pkg::CFG_SRC_HEIGHT: src_h_r <= raas_pkg::CFG_SRC_W'(cfg_chan.data);
        raas_pkg::CFG_DST_WIDTH:  dst_w_r <= cfg_chan.data;
        raas_pkg::CFG_DST_HEIGHT: dst_h_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // sizes saturated to their legal ranges
  always_comb begin
    if (src_w_r == '0)                             sw_eff = SW_W'(1);
    else if (32'(src_w_r) > 32'(MAX_SRC_WIDTH))    sw_eff = SW_W'(MAX_SRC_WIDTH);
    else                                           sw_eff = SW_W'(src_w_r);
    if (src_h_r == '0)                             sh_eff = SH_W'(1);
    else if (32'(src_h_r) > 32'(MAX_SRC_HEIGHT))   sh_eff = SH_W'(MAX_SRC_HEIGHT);
    else                                           sh_eff = SH_W'(src_h_r);
    if (dst_w_r == '0)                             tw_eff = T_W'(1);
    else if (32'(dst_w_r) > 32'(MAX_DST_DIM))      tw_eff = T_W'(MAX_DST_DIM);
    else                                           tw_eff = T_W'(dst_w_r);
    if (dst_h_r == '0)                             th_eff = T_W'(1);
    else if (32'(dst_h_r) > 32'(MAX_DST_DIM))      th_eff = T_W'(MAX_DST_DIM);
    else                                           th_eff = T_W'(dst_h_r);
  end

  // ---------------- input decode ----------------
  assign in_fire = in_chan.valid && in_ready;
  assign is_req  = in_chan.mode == raas_pkg::MODE_REQUEST;
  assign req_bad = (32'(in_chan.target_col) >= 32'(tw_eff)) ||
                   (32'(in_chan.target_row) >= 32'(th_eff));
  assign mem_we  = in_fire && (in_chan.mode == raas_pkg::MODE_WRITE) &&
                   (32'(in_chan.source_col) < 32'(MAX_SRC_WIDTH)) &&
                   (32'(in_chan.source_row) < 32'(MAX_SRC_HEIGHT));
  assign wr_addr = A_W'(32'(in_chan.source_row) * 32'(MAX_SRC_WIDTH) +
                        32'(in_chan.source_col));
  assign rd_addr = A_W'(32'(y_r) * 32'(MAX_SRC_WIDTH) + 32'(x_r));

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= raas_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      raas_pkg::S_IDLE: begin
        if (in_fire && is_req) begin
          state_nxt = req_bad ? raas_pkg::S_OUT : raas_pkg::S_MUL;
        end
      end
      raas_pkg::S_MUL:      state_nxt = raas_pkg::S_SPAN0_GO;
      raas_pkg::S_SPAN0_GO: state_nxt = raas_pkg::S_SPAN0;
      raas_pkg::S_SPAN0: begin
        if (spanx_done) state_nxt = raas_pkg::S_SPAN1_GO;
      end
      raas_pkg::S_SPAN1_GO: state_nxt = raas_pkg::S_SPAN1;
      raas_pkg::S_SPAN1: begin
        if (spanx_done) state_nxt = raas_pkg::S_SUM;
      end
      raas_pkg::S_SUM: begin
        if (last_x && last_y) state_nxt = raas_pkg::S_DRAIN;
      end
      raas_pkg::S_DRAIN:    state_nxt = raas_pkg::S_AVG_GO;
      raas_pkg::S_AVG_GO:   state_nxt = raas_pkg::S_AVG;
      raas_pkg::S_AVG: begin
        if (&avg_done) state_nxt = raas_pkg::S_OUT;
      end
      raas_pkg::S_OUT: begin
        if (!out_valid_r || out_chan.ready) state_nxt = raas_pkg::S_IDLE;
      end
      default: state_nxt = raas_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    span_go  = 1'b0;
    avg_go   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      raas_pkg::S_IDLE:     in_ready = 1'b1;
      raas_pkg::S_SPAN0_GO: span_go  = 1'b1;
      raas_pkg::S_SPAN1_GO: span_go  = 1'b1;
      raas_pkg::S_AVG_GO:   avg_go   = 1'b1;
      raas_pkg::S_OUT:      out_load = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  assign in_chan.ready = in_ready;

  // ---------------- window bounds ----------------
  // first pass divides d*S by T, second pass (d+1)*S = d*S + S
  assign num_x = (state_r == raas_pkg::S_SPAN0_GO) ? px_r : px_r + NX_W'(sw_eff);
  assign num_y = (state_r == raas_pkg::S_SPAN0_GO) ? py_r : py_r + NY_W'(sh_eff);

  raas_div #(.NUM_W(NX_W), .DEN_W(T_W), .QUO_W(SPAN_Q)) u_span_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (span_go),
    .num   (num_x),
    .den   (tw_eff),
    .done  (spanx_done),
    .quo   (spanx_quo)
  );

  raas_div #(.NUM_W(NY_W), .DEN_W(T_W), .QUO_W(SPAN_Q)) u_span_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (span_go),
    .num   (num_y),
    .den   (th_eff),
    .done  (spany_done),
    .quo   (spany_quo)
  );

  // end widened to at least one pixel, then clipped to the source edge
  always_comb begin
    bx = spanx_quo;
    if (bx <= SPAN_Q'(x0_r)) bx = SPAN_Q'(x0_r) + 1'b1;
    if (bx > SPAN_Q'(sw_eff)) bx = SPAN_Q'(sw_eff);
    by = spany_quo;
    if (by <= SPAN_Q'(y0_r)) by = SPAN_Q'(y0_r) + 1'b1;
    if (by > SPAN_Q'(sh_eff)) by = SPAN_Q'(sh_eff);
  end

  assign last_x = SW_W'(x_r + 1'b1) == x1_r;
  assign last_y = SH_W'(y_r + 1'b1) == y1_r;

  // ---------------- frame memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_chan.source_pixel;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= state_r == raas_pkg::S_SUM;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (in_fire && is_req) begin
      dx_r      <= in_chan.target_col;
      dy_r      <= in_chan.target_row;
      res_bad_r <= req_bad;
      res_pix_r <= '0;
    end
    if (state_r == raas_pkg::S_MUL) begin
      px_r <= NX_W'(dx_r * sw_eff);
      py_r <= NY_W'(dy_r * sh_eff);
    end
    if (state_r == raas_pkg::S_SPAN0 && spanx_done && spany_done) begin
      x0_r <= SW_W'(spanx_quo);
      y0_r <= SH_W'(spany_quo);
    end
    if (state_r == raas_pkg::S_SPAN1 && spanx_done && spany_done) begin
      x1_r  <= SW_W'(bx);
      y1_r  <= SH_W'(by);
      x_r   <= x0_r;
      y_r   <= y0_r;
      cnt_r <= '0;
      for (int c = 0; c < raas_pkg::NUM_CH; c++) begin
        acc_r[c] <= '0;
      end
    end
    if (state_r == raas_pkg::S_SUM) begin
      if (last_x) begin
        x_r <= x0_r;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
    if (rd_valid_r) begin
      cnt_r <= cnt_r + 1'b1;
      for (int c = 0; c < raas_pkg::NUM_CH; c++) begin
        acc_r[c] <= acc_r[c] + ACC_W'(rd_data_r[c*raas_pkg::CH_W +: raas_pkg::CH_W]);
      end
    end
    if (state_r == raas_pkg::S_AVG && (&avg_done)) begin
      for (int c = 0; c < raas_pkg::NUM_CH; c++) begin
        res_pix_r[c*raas_pkg::CH_W +: raas_pkg::CH_W] <= avg_quo[c];
      end
    end
  end

  // one divider lane per channel; the average of bytes always fits a byte
  for (genvar g = 0; g < raas_pkg::NUM_CH; g++) begin : g_avg
    raas_div #(.NUM_W(ACC_W), .DEN_W(CNT_W), .QUO_W(raas_pkg::CH_W)) u_avg (
      .clk   (clk),
      .rst_n (rst_n),
      .start (avg_go),
      .num   (acc_r[g]),
      .den   (cnt_r),
      .done  (avg_done[g]),
      .quo   (avg_quo[g])
    );
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r <= res_pix_r;
      out_bad_r <= res_bad_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.averaged_pixel = out_pix_r;
  assign out_chan.bad_request    = out_bad_r;

endmodule

`default_nettype wire
